@@ hw/rtl/mahs_pkg.sv @@
// ----------------------------------------------------------------------------
// mahs_pkg
// shared widths, lookup tables and divider status type for the header scanner
// ----------------------------------------------------------------------------
package mahs_pkg;

  localparam int DIVIDEND_W    = 26;
  localparam int DIVISOR_W     = 17;
  localparam int POS_BITS_DEF  = 32;
  localparam int FSIZE_W       = DIVIDEND_W + 3;

  localparam logic [11:0] MAX_FRAME_RESET = 12'd1280;
  localparam logic [17:0] MUL_LAYER1      = 18'd12000;
  localparam logic [17:0] MUL_LAYER23     = 18'd144000;
  localparam logic [6:0]  BYTES_PER_KBPS  = 7'd125;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_res_t;

  function automatic logic [8:0] kbps_lookup(input logic [2:0] row, input logic [3:0] idx);
    logic [8:0] v;
    v = 9'd0;
    case (row)
      3'd0: begin
        case (idx)
          4'd1: v = 9'd32;   4'd2: v = 9'd64;   4'd3: v = 9'd96;   4'd4: v = 9'd128;
          4'd5: v = 9'd160;  4'd6: v = 9'd192;  4'd7: v = 9'd224;  4'd8: v = 9'd256;
          4'd9: v = 9'd288;  4'd10: v = 9'd320; 4'd11: v = 9'd352; 4'd12: v = 9'd384;
          4'd13: v = 9'd416; 4'd14: v = 9'd448;
          default: v = 9'd0;
        endcase
      end
      3'd1: begin
        case (idx)
          4'd1: v = 9'd32;   4'd2: v = 9'd48;   4'd3: v = 9'd56;   4'd4: v = 9'd64;
          4'd5: v = 9'd80;   4'd6: v = 9'd96;   4'd7: v = 9'd112;  4'd8: v = 9'd128;
          4'd9: v = 9'd160;  4'd10: v = 9'd192; 4'd11: v = 9'd224; 4'd12: v = 9'd256;
          4'd13: v = 9'd320; 4'd14: v = 9'd384;
          default: v = 9'd0;
        endcase
      end
      3'd2: begin
        case (idx)
          4'd1: v = 9'd32;   4'd2: v = 9'd40;   4'd3: v = 9'd48;   4'd4: v = 9'd56;
          4'd5: v = 9'd64;   4'd6: v = 9'd80;   4'd7: v = 9'd96;   4'd8: v = 9'd112;
          4'd9: v = 9'd128;  4'd10: v = 9'd160; 4'd11: v = 9'd192; 4'd12: v = 9'd224;
          4'd13: v = 9'd256; 4'd14: v = 9'd320;
          default: v = 9'd0;
        endcase
      end
      3'd3: begin
        case (idx)
          4'd1: v = 9'd32;   4'd2: v = 9'd48;   4'd3: v = 9'd56;   4'd4: v = 9'd64;
          4'd5: v = 9'd80;   4'd6: v = 9'd96;   4'd7: v = 9'd112;  4'd8: v = 9'd128;
          4'd9: v = 9'd144;  4'd10: v = 9'd160; 4'd11: v = 9'd176; 4'd12: v = 9'd192;
          4'd13: v = 9'd224; 4'd14: v = 9'd256;
          default: v = 9'd0;
        endcase
      end
      3'd4: begin
        case (idx)
          4'd1: v = 9'd8;    4'd2: v = 9'd16;   4'd3: v = 9'd24;   4'd4: v = 9'd32;
          4'd5: v = 9'd40;   4'd6: v = 9'd48;   4'd7: v = 9'd56;   4'd8: v = 9'd64;
          4'd9: v = 9'd80;   4'd10: v = 9'd96;  4'd11: v = 9'd112; 4'd12: v = 9'd128;
          4'd13: v = 9'd144; 4'd14: v = 9'd160;
          default: v = 9'd0;
        endcase
      end
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] freq_lookup(input logic [3:0] idx);
    logic [15:0] v;
    case (idx)
      4'd0: v = 16'd44100;
      4'd1: v = 16'd48000;
      4'd2: v = 16'd32000;
      4'd3: v = 16'd22050;
      4'd4: v = 16'd24000;
      4'd5: v = 16'd16000;
      4'd6: v = 16'd11025;
      4'd7: v = 16'd12000;
      4'd8: v = 16'd8000;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/mahs_div.sv @@
// ----------------------------------------------------------------------------
// mahs_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mahs_div
  import mahs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output div_res_t              res
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] dvd_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dsr_r;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  qbit;
  logic [DIVISOR_W:0]    rem_sub;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[DIVIDEND_W-1]};
    qbit    = rem_sh >= {1'b0, dsr_r};
    rem_sub = qbit ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DIVIDEND_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIVIDEND_W-2:0], qbit};
      rem_r <= rem_sub[DIVISOR_W-1:0];
    end
  end

  assign res.done     = done_r;
  assign res.quotient = dvd_r;

endmodule

@@ hw/rtl/mpeg_audio_header_sync_core.sv @@
// ----------------------------------------------------------------------------
// mpeg_audio_header_sync_core
// byte stream scanner for mpeg audio frame headers
// ----------------------------------------------------------------------------
// a byte that does not complete a candidate header leaves in_ready high
// a candidate header goes from accept to result through a setup state,
// 26 steps of the restoring divider for the frame size, then a finish state
// in_ready is low while a candidate is worked on
// synchronous active-low reset clears window, fill, position, result valid
// and restores max_frame_size to 1280
module mpeg_audio_header_sync_core
  import mahs_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_header_position,
  output logic [1:0]  out_layer,
  output logic [11:0] out_frame_size,
  output logic [15:0] out_byte_rate,
  output logic [15:0] out_sample_rate,
  output logic [1:0]  out_channels,
  output logic        out_low_rate_flag,
  output logic        out_crc_present,
  output logic        out_padded
);

  localparam int POS_EXT = (POSITION_BITS > 32) ? POSITION_BITS : 32;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [11:0]              max_r;
  logic [23:0]              win_r;
  logic [1:0]               fill_r;
  logic [POSITION_BITS-1:0] pos_r;

  logic [8:0]               kbps_r;
  logic [15:0]              freq_r;
  logic [1:0]               layer_r;
  logic                     lsf_r, crc_r, pad_r, mono_r;
  logic [31:0]              hp_r;

  logic                     ovalid_r;

  logic                     in_acc;
  logic [31:0]              hdr;
  logic [1:0]               fill_eff;
  logic [POSITION_BITS-1:0] pos_eff;
  logic [POSITION_BITS-1:0] hp;
  logic [POS_EXT-1:0]       hp_ext;
  logic [1:0]               ver, lcode, sr_bits, layer_d;
  logic [3:0]               br_idx, sr_idx;
  logic [2:0]               row;
  logic                     lsf_d;
  logic                     hdr_ok;

  logic                     div_start;
  logic [DIVIDEND_W-1:0]    div_dividend;
  logic [DIVISOR_W-1:0]     div_divisor;
  div_res_t                 div_res;
  logic [26:0]              mul_prod;

  logic [DIVIDEND_W:0]      qsum;
  logic [FSIZE_W-1:0]       fsize;
  logic                     fsize_ok;
  logic                     out_load;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    fill_eff = in_restart ? 2'd0 : fill_r;
    pos_eff  = in_restart ? '0 : pos_r;
    hp       = pos_eff - POSITION_BITS'(3);
    hp_ext   = POS_EXT'(hp);
    hdr      = {(in_restart ? 24'd0 : win_r), in_data_byte};
    ver      = hdr[20:19];
    lcode    = hdr[18:17];
    br_idx   = hdr[15:12];
    sr_bits  = hdr[11:10];
    layer_d  = 2'(3'd4 - {1'b0, lcode});
    lsf_d    = (ver != 2'd3);
    case (ver)
      2'd0:    sr_idx = 4'd6 + {2'b00, sr_bits};
      2'd2:    sr_idx = 4'd3 + {2'b00, sr_bits};
      default: sr_idx = {2'b00, sr_bits};
    endcase
    if (lsf_d) row = (layer_d == 2'd1) ? 3'd3 : 3'd4;
    else       row = {1'b0, layer_d - 2'd1};
    hdr_ok = (fill_eff == 2'd3) && (&hdr[31:21]) && (ver != 2'd1) && (lcode != 2'd0)
             && (br_idx != 4'd0) && (br_idx != 4'd15) && (sr_bits != 2'd3);
  end

  always_comb begin
    mul_prod     = kbps_r * ((layer_r == 2'd1) ? MUL_LAYER1 : MUL_LAYER23);
    div_dividend = mul_prod[DIVIDEND_W-1:0];
    div_divisor  = (layer_r == 2'd3 && lsf_r) ? {freq_r, 1'b0} : {1'b0, freq_r};
    div_start    = (state_r == S_MUL);
  end

  mahs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  always_comb begin
    qsum     = {1'b0, div_res.quotient} + (DIVIDEND_W+1)'(pad_r);
    fsize    = (layer_r == 2'd1) ? {qsum, 2'b00} : {2'b00, qsum};
    fsize_ok = (fsize != '0) && (fsize <= FSIZE_W'(max_r));
    out_load = (state_r == S_FIN) && fsize_ok && (!ovalid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc && hdr_ok) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  if (div_res.done) state_nxt = S_FIN;
      S_FIN:  if (!fsize_ok || out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      max_r    <= MAX_FRAME_RESET;
      win_r    <= '0;
      fill_r   <= '0;
      pos_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) max_r <= cfg_wr_data;
      if (in_acc) begin
        win_r  <= hdr[23:0];
        fill_r <= (fill_eff == 2'd3) ? 2'd3 : fill_eff + 2'd1;
        pos_r  <= pos_eff + POSITION_BITS'(1);
      end
      if (out_load)       ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && hdr_ok) begin
      kbps_r  <= kbps_lookup(row, br_idx);
      freq_r  <= freq_lookup(sr_idx);
      layer_r <= layer_d;
      lsf_r   <= lsf_d;
      crc_r   <= ~hdr[16];
      pad_r   <= hdr[9];
      mono_r  <= (hdr[7:6] == 2'd3);
      hp_r    <= hp_ext[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_header_position <= hp_r;
      out_layer           <= layer_r;
      out_frame_size      <= fsize[11:0];
      out_byte_rate       <= 16'(kbps_r) * 16'(BYTES_PER_KBPS);
      out_sample_rate     <= freq_r;
      out_channels        <= mono_r ? 2'd1 : 2'd2;
      out_low_rate_flag   <= lsf_r;
      out_crc_present     <= crc_r;
      out_padded          <= pad_r;
    end
  end

  assign out_valid = ovalid_r;

endmodule

@@ hw/rtl/mahs_checker.sv @@
// ----------------------------------------------------------------------------
// mahs_checker
// port-level checks for the header scanner, bound to the top level
// ----------------------------------------------------------------------------
module mahs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_header_position,
  input logic [1:0]  out_layer,
  input logic [11:0] out_frame_size,
  input logic [15:0] out_sample_rate,
  input logic [1:0]  out_channels,
  input logic        out_low_rate_flag
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_header_position)
                                && $stable(out_frame_size))
    else $error("stalled result changed");

  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_layer != 2'd0 && out_frame_size != 12'd0
                  && (out_channels == 2'd1 || out_channels == 2'd2))
    else $error("bad result fields");

  a_rate_version: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_low_rate_flag |-> out_sample_rate >= 16'd32000)
    else $error("sample rate does not match version");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input item withdrawn before accept");

endmodule

bind mpeg_audio_header_sync_core mahs_checker u_mahs_checker (.*);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the mpeg audio frame header scanner
// ----------------------------------------------------------------------------
// feeds byte streams through the valid/ready input, decodes every four-byte
// window in a local header decoder and compares each header result, field by
// field, with the oldest pending prediction. covers window fill and restart,
// every version and layer, each rejection rule, the frame size limit at its
// boundary and extremes, random streams under random stalls, a long output
// hold-off that backs up the input, and a sender pause that drains the block.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 2;
  localparam int RESET_CYCLES   = 11;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 600;
  localparam int IDLE_PERCENT   = 8;

  localparam logic [1:0] VER_MPEG25     = 2'b00;
  localparam logic [1:0] VER_RESERVED   = 2'b01;
  localparam logic [1:0] VER_MPEG2      = 2'b10;
  localparam logic [1:0] VER_MPEG1      = 2'b11;
  localparam logic [1:0] LAYER_RESERVED = 2'b00;
  localparam logic [3:0] BR_FREE        = 4'd0;
  localparam logic [3:0] BR_BAD         = 4'd15;
  localparam logic [1:0] SR_RESERVED    = 2'd3;
  localparam logic [1:0] MODE_MONO      = 2'd3;

  localparam logic [31:0] HDR_L3_128K   = 32'hFFFA9044;
  localparam logic [31:0] HDR_V2_L2_PAD = 32'hFFF5E6C0;
  localparam logic [31:0] HDR_V25_L1    = 32'hFFE61200;
  localparam logic [31:0] HDR_BAD_VER   = 32'hFFEB9044;
  localparam logic [31:0] HDR_BAD_LAYER = 32'hFFF99044;
  localparam logic [31:0] HDR_BAD_BR    = 32'hFFFAF044;
  localparam logic [31:0] HDR_BAD_SR    = 32'hFFFA9C44;
  localparam logic [31:0] HDR_LARGEST   = 32'hFFE5EA80;

  typedef enum int {
    FLAW_NONE, FLAW_SYNC, FLAW_VERSION, FLAW_LAYER, FLAW_BITRATE, FLAW_RATE
  } hdr_flaw_t;

  typedef struct packed {
    logic [31:0] position;
    logic [1:0]  layer;
    logic [11:0] frame_size;
    logic [15:0] byte_rate;
    logic [15:0] sample_rate;
    logic [1:0]  channels;
    logic        low_rate;
    logic        crc;
    logic        padded;
  } frame_hdr_t;

  int unsigned kbps_tab [5][16] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
  };
  int unsigned freq_tab [9] = '{
    44100, 48000, 32000, 22050, 24000, 16000, 11025, 12000, 8000
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [11:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_header_position;
  logic [1:0]  out_layer;
  logic [11:0] out_frame_size;
  logic [15:0] out_byte_rate;
  logic [15:0] out_sample_rate;
  logic [1:0]  out_channels;
  logic        out_low_rate_flag;
  logic        out_crc_present;
  logic        out_padded;

  frame_hdr_t  expected_hdrs[$];
  frame_hdr_t  exp_hdr;
  logic [23:0] scan_window = '0;
  logic [1:0]  scan_fill = '0;
  logic [31:0] scan_pos = '0;
  logic [11:0] max_frame = mahs_pkg::MAX_FRAME_RESET;
  int unsigned bytes_taken = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int          hold_req = 0;
  int          hold_left = 0;
  bit          no_idle = 1'b0;

  mpeg_audio_header_sync_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_restart          (in_restart),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_header_position (out_header_position),
    .out_layer           (out_layer),
    .out_frame_size      (out_frame_size),
    .out_byte_rate       (out_byte_rate),
    .out_sample_rate     (out_sample_rate),
    .out_channels        (out_channels),
    .out_low_rate_flag   (out_low_rate_flag),
    .out_crc_present     (out_crc_present),
    .out_padded          (out_padded)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic bit decode_frame_header(input logic [31:0] h, input logic [11:0] limit,
                                             output frame_hdr_t f);
    logic [1:0]  ver;
    logic [1:0]  lcode;
    logic [1:0]  sr;
    logic [3:0]  br;
    int unsigned layer, lsf, sr_idx, row, kbps, freq, fsize, pad;
    f = '0;
    ver   = h[20:19];
    lcode = h[18:17];
    br    = h[15:12];
    sr    = h[11:10];
    if (h[31:21] != 11'h7FF || ver == VER_RESERVED || lcode == LAYER_RESERVED) return 1'b0;
    if (br == BR_FREE || br == BR_BAD || sr == SR_RESERVED) return 1'b0;
    layer  = 4 - lcode;
    lsf    = (ver == VER_MPEG1) ? 0 : 1;
    sr_idx = (ver == VER_MPEG25) ? 6 + sr : sr + 3 * lsf;
    if (sr_idx > 8) return 1'b0;
    row  = lsf ? ((layer == 1) ? 3 : 4) : layer - 1;
    kbps = kbps_tab[row][br];
    freq = freq_tab[sr_idx];
    pad  = h[9];
    if (layer == 1) fsize = ((kbps * 12000) / freq + pad) << 2;
    else if (layer == 3) fsize = (kbps * 144000) / (freq << lsf) + pad;
    else fsize = (kbps * 144000) / freq + pad;
    if (fsize == 0 || fsize > limit) return 1'b0;
    f.layer       = layer[1:0];
    f.frame_size  = fsize[11:0];
    f.byte_rate   = 16'(kbps * 125);
    f.sample_rate = freq[15:0];
    f.channels    = (h[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
    f.low_rate    = lsf[0];
    f.crc         = ~h[16];
    f.padded      = h[9];
    return 1'b1;
  endfunction

  task automatic track_stream_byte(input logic [7:0] b, input logic rs);
    frame_hdr_t f;
    if (rs) begin
      scan_window = '0;
      scan_fill = '0;
      scan_pos = '0;
    end
    if (scan_fill == 2'd3 && decode_frame_header({scan_window, b}, max_frame, f)) begin
      f.position = scan_pos - 32'd3;
      expected_hdrs.push_back(f);
    end
    scan_window = {scan_window[15:0], b};
    if (scan_fill != 2'd3) scan_fill = scan_fill + 2'd1;
    scan_pos = scan_pos + 32'd1;
    bytes_taken++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic rs);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_restart <= rs;
    do @(posedge clk); while (!in_ready);
    track_stream_byte(b, rs);
  endtask

  task automatic send_word(input logic [31:0] w, input logic rs);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8], rs && i == 3);
  endtask

  // sender stops and the block drains, including any candidate still in the divider
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_hdrs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_max_frame(input logic [11:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_frame = v;
  endtask

  function automatic logic [31:0] make_header(input hdr_flaw_t flaw);
    logic [31:0] h;
    h = $urandom;
    h[31:21] = '1;
    case ($urandom_range(0, 2))
      0: h[20:19] = VER_MPEG1;
      1: h[20:19] = VER_MPEG2;
      default: h[20:19] = VER_MPEG25;
    endcase
    h[18:17] = 2'($urandom_range(1, 3));
    h[15:12] = 4'($urandom_range(1, 14));
    h[11:10] = 2'($urandom_range(0, 2));
    case (flaw)
      FLAW_SYNC: h[21 + $urandom_range(0, 10)] = 1'b0;
      FLAW_VERSION: h[20:19] = VER_RESERVED;
      FLAW_LAYER: h[18:17] = LAYER_RESERVED;
      FLAW_BITRATE: h[15:12] = $urandom_range(0, 1) ? BR_FREE : BR_BAD;
      FLAW_RATE: h[11:10] = SR_RESERVED;
      default: ;
    endcase
    return h;
  endfunction

  task automatic test_window_fill();
    send_word(HDR_L3_128K, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFA, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h44, 1'b1);
    send_word(HDR_V25_L1, 1'b0);
  endtask

  task automatic test_header_fields();
    send_word(HDR_V2_L2_PAD, 1'b0);
    send_word(HDR_BAD_VER, 1'b0);
    send_word(HDR_BAD_LAYER, 1'b0);
    send_word(HDR_BAD_BR, 1'b0);
    send_word(HDR_BAD_SR, 1'b0);
  endtask

  task automatic test_frame_limit();
    set_max_frame(12'd417);
    send_word(HDR_L3_128K, 1'b1);
    set_max_frame(12'd416);
    send_word(HDR_L3_128K, 1'b1);
    set_max_frame(12'd4095);
    send_word(HDR_LARGEST, 1'b0);
    set_max_frame(12'd1);
    send_word(HDR_V25_L1, 1'b0);
  endtask

  task automatic test_random_stream(input int n_items);
    int unsigned stop_at;
    int          pick;
    int          k;
    logic [31:0] w;
    stop_at = bytes_taken + n_items;
    while (bytes_taken < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_word(make_header(FLAW_NONE), $urandom_range(0, 19) == 0);
        repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
      end else if (pick < 80) begin
        send_word(make_header(hdr_flaw_t'($urandom_range(1, 5))), 1'b0);
      end else if (pick < 88) begin
        // header cut short by a restart
        w = make_header(FLAW_NONE);
        k = $urandom_range(1, 3);
        for (int i = 0; i < k; i++) send_byte(w[31-8*i -: 8], 1'b0);
        send_byte(8'($urandom), 1'b1);
      end else begin
        repeat ($urandom_range(1, 8))
          send_byte(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom),
                    $urandom_range(0, 49) == 0);
      end
    end
  endtask

  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    repeat (40) send_word(make_header(FLAW_NONE), 1'b0);
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_hdrs.size() == 0) begin
        $error("unexpected header result at position %0d", out_header_position);
        mismatches++;
      end else begin
        exp_hdr = expected_hdrs.pop_front();
        compare_field("header_position", exp_hdr.position, out_header_position);
        compare_field("layer", exp_hdr.layer, out_layer);
        compare_field("frame_size", exp_hdr.frame_size, out_frame_size);
        compare_field("byte_rate", exp_hdr.byte_rate, out_byte_rate);
        compare_field("sample_rate", exp_hdr.sample_rate, out_sample_rate);
        compare_field("channels", exp_hdr.channels, out_channels);
        compare_field("low_rate_flag", exp_hdr.low_rate, out_low_rate_flag);
        compare_field("crc_present", exp_hdr.crc, out_crc_present);
        compare_field("padded", exp_hdr.padded, out_padded);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_window_fill();
    test_header_fields();
    test_frame_limit();
    set_max_frame(12'd4095);
    test_random_stream(220);
    set_max_frame(12'($urandom_range(1, 4095)));
    no_idle = 1'b1;
    test_random_stream(220);
    no_idle = 1'b0;
    set_max_frame(mahs_pkg::MAX_FRAME_RESET);
    test_backpressure();
    test_random_stream(220);
    wait_drained();
    if (expected_hdrs.size() != 0) begin
      $error("%0d header results never arrived", expected_hdrs.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
